FILE: sv/stbs_pkg.sv
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and constants of the sorted table search unit.
// ----------------------------------------------------------------------------
package stbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  // table_length and the search window bounds hold 0..TABLE_DEPTH
  localparam int LEN_W       = ADDR_W + 1;
  localparam int INDEX_W     = 10;
  localparam int CFG_W       = 11;

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [LEN_W-1:0]       len_t;

  typedef enum logic {
    ACT_WRITE  = 1'b0,
    ACT_SEARCH = 1'b1
  } action_e;

  typedef enum logic {
    REG_TABLE_LENGTH = 1'b0,
    REG_MATCH_MODE   = 1'b1
  } reg_idx_e;

  typedef enum logic {
    MODE_ANY      = 1'b0,
    MODE_LEFTMOST = 1'b1
  } match_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CHECK,
    ST_DONE
  } state_e;

  // memory access bundle from the sequencer to the table store
  typedef struct packed {
    logic   wr_en;
    addr_t  wr_addr;
    value_t wr_data;
    logic   rd_en;
    addr_t  rd_addr;
  } mem_req_t;

endpackage

FILE: sv/stbs_table.sv
// ----------------------------------------------------------------------------
// stbs_table
// Single-port-write, registered-read table store holding the sorted words.
// ----------------------------------------------------------------------------
module stbs_table (
  input  logic              clk_i,
  input  stbs_pkg::mem_req_t req_i,
  output stbs_pkg::value_t  rd_data_o
);
  import stbs_pkg::*;

  value_t mem [TABLE_DEPTH];
  value_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: sv/sorted_table_binary_search_unit.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search_unit
// Bisection search over a table of signed words kept in ascending order.
// ----------------------------------------------------------------------------
// A write beat stores one entry and gives no result; writes can follow each
// other every cycle while no search runs. A search beat runs a bisection
// through one shared compare unit and the table's single registered read
// port: each step issues an address, then compares the word read. A search
// over a full table of 1024 entries takes 10 or 11 bisection steps in mode
// 1, and in mode 0 when the key is missing; a hit in mode 0 ends at the step
// that finds it. Match mode 0 returns the first hit met by plain bisection,
// mode 1 the leftmost occurrence (one extra read to confirm). An empty
// table reports not found. The unit is busy during a search; the finished
// result sits in an output register so the next beat is taken while it
// waits, and a search finishing while that register is still full holds
// until it drains.
module sorted_table_binary_search_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [stbs_pkg::CFG_W-1:0] cfg_data_i,
  // input stream
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [79:0]              s_axis_tdata,  // entry_index, entry_value, search_key
  input  logic                     s_axis_tuser,  // action
  // result stream
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [15:0]              m_axis_tdata,  // match_index
  output logic                     m_axis_tuser   // found
);
  import stbs_pkg::*;

  logic [INDEX_W-1:0] in_entry_index;
  value_t             in_entry_value;
  value_t             in_search_key;

  assign in_entry_index = s_axis_tdata[INDEX_W-1:0];
  assign in_entry_value = s_axis_tdata[INDEX_W +: VALUE_WIDTH];
  assign in_search_key  = s_axis_tdata[INDEX_W+VALUE_WIDTH +: VALUE_WIDTH];

  localparam len_t DEPTH_L = len_t'(TABLE_DEPTH);

  state_e state_q, state_d;
  len_t   len_q;
  logic   mode_q;
  len_t   lo_q, lo_d, hi_q, hi_d, n_q, n_d, mid_q, mid_d;
  value_t key_q, key_d;
  logic   final_q, final_d;
  logic   res_found_q, res_found_d;
  logic [INDEX_W-1:0] res_idx_q, res_idx_d;
  logic   out_valid_q, out_valid_d;
  logic   out_found_q, out_found_d;
  logic [INDEX_W-1:0] out_idx_q, out_idx_d;

  mem_req_t mem_req;
  value_t   rd_data;
  logic [LEN_W:0] mid_sum;
  len_t     mid;
  logic     accept;
  logic     out_free;
  logic     rd_eq, rd_lt;

  stbs_table u_table (
    .clk_i    (clk_i),
    .req_i    (mem_req),
    .rd_data_o(rd_data)
  );

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // mode 0 probes floor((left+right)/2) with right = hi-1
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q}
                   - {{LEN_W{1'b0}}, (mode_q == MODE_ANY)};
  assign mid     = mid_sum[LEN_W:1];

  assign rd_eq = (rd_data == key_q);
  assign rd_lt = ($signed(rd_data) < $signed(key_q));

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      mode_q <= MODE_ANY;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TABLE_LENGTH: len_q  <= cfg_data_i;
        REG_MATCH_MODE:   mode_q <= cfg_data_i[0];
        default:          ;
      endcase
    end
  end

  // next state and datapath
  always_comb begin
    state_d     = state_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    n_d         = n_q;
    mid_d       = mid_q;
    key_d       = key_q;
    final_d     = final_q;
    res_found_d = res_found_q;
    res_idx_d   = res_idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && s_axis_tuser == ACT_SEARCH) begin
          n_d     = (len_q > DEPTH_L) ? DEPTH_L : len_q;
          lo_d    = '0;
          hi_d    = (len_q > DEPTH_L) ? DEPTH_L : len_q;
          key_d   = in_search_key;
          final_d = 1'b0;
          state_d = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (lo_q < hi_q) begin
          mid_d   = mid;
          state_d = ST_CHECK;
        end else if (mode_q == MODE_LEFTMOST && lo_q < n_q) begin
          final_d = 1'b1;
          state_d = ST_CHECK;
        end else begin
          res_found_d = 1'b0;
          res_idx_d   = '0;
          state_d     = ST_DONE;
        end
      end
      ST_CHECK: begin
        priority if (final_q) begin
          res_found_d = rd_eq;
          res_idx_d   = rd_eq ? INDEX_W'(lo_q) : '0;
          state_d     = ST_DONE;
        end else if (mode_q == MODE_ANY && rd_eq) begin
          res_found_d = 1'b1;
          res_idx_d   = INDEX_W'(mid_q);
          state_d     = ST_DONE;
        end else if (rd_lt) begin
          lo_d    = mid_q + len_t'(1);
          state_d = ST_PROBE;
        end else begin
          hi_d    = mid_q;
          state_d = ST_PROBE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_found_d = out_found_q;
    out_idx_d   = out_idx_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (state_q == ST_DONE && out_free) begin
      out_valid_d = 1'b1;
      out_found_d = res_found_q;
      out_idx_d   = res_idx_q;
    end
  end

  // control outputs
  always_comb begin
    s_axis_tready   = (state_q == ST_IDLE);
    mem_req.wr_en   = accept && (s_axis_tuser == ACT_WRITE)
                      && ({1'b0, in_entry_index} < (INDEX_W+1)'(TABLE_DEPTH));
    mem_req.wr_addr = ADDR_W'(in_entry_index);
    mem_req.wr_data = in_entry_value;
    mem_req.rd_en   = (state_q == ST_PROBE);
    mem_req.rd_addr = (lo_q < hi_q) ? mid[ADDR_W-1:0] : lo_q[ADDR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    n_q         <= n_d;
    mid_q       <= mid_d;
    key_q       <= key_d;
    final_q     <= final_d;
    res_found_q <= res_found_d;
    res_idx_q   <= res_idx_d;
    out_found_q <= out_found_d;
    out_idx_q   <= out_idx_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tdata  = {{(16-INDEX_W){1'b0}}, out_idx_q};

endmodule
